// ===== rtl/core/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int DEF_WORD_BITS = 32;
	localparam int OPER_W        = 32;
	localparam int PROD_W        = 64;
	localparam int RES_DEN_W     = 31;

	localparam logic [2:0] KIND_ADD = 3'd0;
	localparam logic [2:0] KIND_SUB = 3'd1;
	localparam logic [2:0] KIND_MUL = 3'd2;
	localparam logic [2:0] KIND_DIV = 3'd3;
	localparam logic [2:0] KIND_CMP = 3'd4;

	localparam logic [1:0] REL_LESS    = 2'd0;
	localparam logic [1:0] REL_EQUAL   = 2'd1;
	localparam logic [1:0] REL_GREATER = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic              go;
		logic [PROD_W-1:0] num;
		logic [PROD_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quot;
		logic [PROD_W-1:0] rem;
	} div_rsp_t;

endpackage

// ===== rtl/core/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rau_pkg::div_req_t req,
	output rau_pkg::div_rsp_t rsp
);

	localparam int W   = rau_pkg::PROD_W;
	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     quo_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [W:0]       shifted;
	logic [W:0]       diff;

	// trial subtract of the shifted partial remainder
	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: load operands, then shift one bit per cycle
	always_ff @(posedge clk) begin
		if (req.go) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (run_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== rtl/core/rau_mul.sv =====
// ----------------------------------------------------------------------------
// rau_mul
// Shared unsigned 32 by 32 multiplier with registered product.
// ----------------------------------------------------------------------------
module rau_mul (
	input  logic                         clk,
	input  logic [rau_pkg::OPER_W-1:0]   op_a,
	input  logic [rau_pkg::OPER_W-1:0]   op_b,
	output logic [rau_pkg::PROD_W-1:0]   prod
);

	logic [rau_pkg::PROD_W-1:0] prod_q;

	// register the product for the next sequencer step
	always_ff @(posedge clk) begin
		prod_q <= rau_pkg::PROD_W'(op_a) * rau_pkg::PROD_W'(op_b);
	end

	assign prod = prod_q;

endmodule

// ===== rtl/core/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Add, subtract, multiply, divide and compare of signed fractions, with
// GCD reduction, run by a sequencer over one shared divider and multiplier.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  input   | start && !busy     | kind, a_num, a_den, b_num, b_den
//  result  | done (one cycle)   | res_num, res_den, relation, status
//
//  Error items give their result in the cycle after acceptance.
//  Compare, multiply and divide form two cross products; only multiply and
//  divide then run the final reduction. Each GCD strips common factors of
//  two, then runs Euclid remainder steps on the shared 64-bit divider, which
//  also runs each exact division. Add/subtract run two GCDs and four divisions.
//  Reset clears the sequencer; busy stays high until the result strobes.
//  The receiver cannot stall: done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
	parameter int WORD_BITS = rau_pkg::DEF_WORD_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	output logic        done,
	output logic signed [31:0] res_num,
	output logic [30:0] res_den,
	output logic [1:0]  relation,
	output logic [1:0]  status
);

	localparam int OW = rau_pkg::OPER_W;
	localparam int PW = rau_pkg::PROD_W;
	localparam int EB = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam logic [PW-1:0] TOP = PW'(1) << (EB - 1);

	typedef enum logic [4:0] {
		S_IDLE, S_ADD_GCD, S_ADD_Q1, S_ADD_Q2, S_ADD_M1, S_ADD_M2, S_ADD_M3,
		S_ADD_SUM, S_PROD1, S_PROD2, S_PROD3, S_FIN_GCD, S_FIN_Q1, S_FIN_Q2,
		S_FIN_CHK, S_G_INIT, S_G_STRIP, S_G_EUC, S_G_STEP, S_DIV_WAIT
	} state_t;

	state_t state_q, gret_q, dret_q;

	logic [2:0]    kind_q;
	logic          sa_q, sb_q, neg_q;
	logic [OW-1:0] ma_q, da_q, mb_q, db_q, q1_q, q2_q;
	logic [PW-1:0] nmag_q, nden_q, ga_q, gb_q, g_q;
	logic [5:0]    sh_q;

	logic          done_q;
	logic [31:0]   res_num_q;
	logic [30:0]   res_den_q;
	logic [1:0]    relation_q, status_q;

	rau_pkg::div_req_t div_req;
	rau_pkg::div_rsp_t div_rsp;
	logic [OW-1:0] mul_a, mul_b;
	logic [PW-1:0] prod;

	logic          in_err;
	logic          sbe;
	logic [PW-1:0] ovf_max;

	rau_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	rau_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(prod));

	// reject zero denominators, divide by zero and unknown kinds
	assign in_err = (a_den == '0) || (b_den == '0) || (kind > rau_pkg::KIND_CMP)
		|| ((kind == rau_pkg::KIND_DIV) && (b_num == '0));

	assign sbe     = sb_q ^ (kind_q == rau_pkg::KIND_SUB);
	assign ovf_max = (neg_q && (nmag_q != '0)) ? TOP : TOP - 1'b1;

	// select multiplier operands per step
	always_comb begin
		mul_a = ma_q;
		mul_b = mb_q;
		unique case (state_q)
			S_ADD_M1: begin mul_a = q1_q; mul_b = db_q; end
			S_ADD_M2: begin mul_a = ma_q; mul_b = q2_q; end
			S_ADD_M3: begin mul_a = mb_q; mul_b = q1_q; end
			S_PROD1: begin
				mul_a = ma_q;
				mul_b = (kind_q == rau_pkg::KIND_MUL) ? mb_q : db_q;
			end
			S_PROD2: begin
				if (kind_q == rau_pkg::KIND_MUL) begin
					mul_a = da_q; mul_b = db_q;
				end else if (kind_q == rau_pkg::KIND_DIV) begin
					mul_a = da_q; mul_b = mb_q;
				end else begin
					mul_a = mb_q; mul_b = da_q;
				end
			end
			default: ;
		endcase
	end

	// issue divider requests per step
	always_comb begin
		div_req.go  = 1'b0;
		div_req.num = ga_q;
		div_req.den = gb_q;
		unique case (state_q)
			S_G_EUC:  div_req.go = (gb_q != '0);
			S_ADD_Q1: begin div_req.go = 1'b1; div_req.num = PW'(da_q); div_req.den = g_q; end
			S_ADD_Q2: begin div_req.go = 1'b1; div_req.num = PW'(db_q); div_req.den = g_q; end
			S_FIN_Q1: begin div_req.go = 1'b1; div_req.num = nmag_q; div_req.den = g_q; end
			S_FIN_Q2: begin div_req.go = 1'b1; div_req.num = nden_q; div_req.den = g_q; end
			default: ;
		endcase
	end

	// sequencer with registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gret_q  <= S_IDLE;
			dret_q  <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q <= kind;
						sa_q   <= (a_num != '0) && (a_num[31] ^ a_den[31]);
						sb_q   <= (b_num != '0) && (b_num[31] ^ b_den[31]);
						ma_q   <= a_num[31] ? OW'(-a_num) : OW'(a_num);
						mb_q   <= b_num[31] ? OW'(-b_num) : OW'(b_num);
						da_q   <= a_den[31] ? OW'(-a_den) : OW'(a_den);
						db_q   <= b_den[31] ? OW'(-b_den) : OW'(b_den);
						if (in_err) begin
							done_q     <= 1'b1;
							res_num_q  <= '0;
							res_den_q  <= 31'd1;
							relation_q <= rau_pkg::REL_EQUAL;
							status_q   <= rau_pkg::ST_ZERO_DEN;
						end else if (kind == rau_pkg::KIND_ADD || kind == rau_pkg::KIND_SUB) begin
							state_q <= S_ADD_GCD;
						end else begin
							state_q <= S_PROD1;
						end
					end
				end
				S_ADD_GCD: begin
					ga_q    <= PW'(da_q);
					gb_q    <= PW'(db_q);
					gret_q  <= S_ADD_Q1;
					state_q <= S_G_INIT;
				end
				S_ADD_Q1: begin
					dret_q  <= S_ADD_Q2;
					state_q <= S_DIV_WAIT;
				end
				S_ADD_Q2: begin
					q1_q    <= div_rsp.quot[OW-1:0];
					dret_q  <= S_ADD_M1;
					state_q <= S_DIV_WAIT;
				end
				S_ADD_M1: begin
					q2_q    <= div_rsp.quot[OW-1:0];
					state_q <= S_ADD_M2;
				end
				S_ADD_M2: begin
					nden_q  <= prod;
					state_q <= S_ADD_M3;
				end
				S_ADD_M3: begin
					nmag_q  <= prod;
					state_q <= S_ADD_SUM;
				end
				S_ADD_SUM: begin
					// combine scaled magnitudes by sign
					if (sa_q == sbe) begin
						nmag_q <= nmag_q + prod;
						neg_q  <= sa_q;
					end else if (nmag_q >= prod) begin
						nmag_q <= nmag_q - prod;
						neg_q  <= sa_q;
					end else begin
						nmag_q <= prod - nmag_q;
						neg_q  <= sbe;
					end
					state_q <= S_FIN_GCD;
				end
				S_PROD1: state_q <= S_PROD2;
				S_PROD2: begin
					nmag_q  <= prod;
					state_q <= S_PROD3;
				end
				S_PROD3: begin
					if (kind_q == rau_pkg::KIND_CMP) begin
						// left magnitude in nmag_q, right in prod
						done_q    <= 1'b1;
						res_num_q <= '0;
						res_den_q <= 31'd1;
						status_q  <= rau_pkg::ST_OK;
						if (sa_q != sb_q) begin
							relation_q <= sa_q ? rau_pkg::REL_LESS : rau_pkg::REL_GREATER;
						end else if (nmag_q == prod) begin
							relation_q <= rau_pkg::REL_EQUAL;
						end else if ((nmag_q < prod) ^ sa_q) begin
							relation_q <= rau_pkg::REL_LESS;
						end else begin
							relation_q <= rau_pkg::REL_GREATER;
						end
						state_q <= S_IDLE;
					end else begin
						nden_q  <= prod;
						neg_q   <= sa_q ^ sb_q;
						state_q <= S_FIN_GCD;
					end
				end
				S_FIN_GCD: begin
					ga_q    <= nmag_q;
					gb_q    <= nden_q;
					gret_q  <= S_FIN_Q1;
					state_q <= S_G_INIT;
				end
				S_FIN_Q1: begin
					dret_q  <= S_FIN_Q2;
					state_q <= S_DIV_WAIT;
				end
				S_FIN_Q2: begin
					nmag_q  <= div_rsp.quot;
					dret_q  <= S_FIN_CHK;
					state_q <= S_DIV_WAIT;
				end
				S_FIN_CHK: begin
					done_q     <= 1'b1;
					relation_q <= rau_pkg::REL_EQUAL;
					if (nmag_q > ovf_max || div_rsp.quot > TOP - 1'b1) begin
						res_num_q <= '0;
						res_den_q <= 31'd1;
						status_q  <= rau_pkg::ST_OVERFLOW;
					end else begin
						res_num_q <= neg_q ? -nmag_q[31:0] : nmag_q[31:0];
						res_den_q <= div_rsp.quot[30:0];
						status_q  <= rau_pkg::ST_OK;
					end
					state_q <= S_IDLE;
				end
				// GCD: zero shortcuts, strip twos, Euclid remainder loop
				S_G_INIT: begin
					sh_q <= '0;
					if (ga_q == '0) begin
						g_q     <= gb_q;
						state_q <= gret_q;
					end else if (gb_q == '0) begin
						g_q     <= ga_q;
						state_q <= gret_q;
					end else begin
						state_q <= S_G_STRIP;
					end
				end
				S_G_STRIP: begin
					if (!(ga_q[0] | gb_q[0])) begin
						ga_q <= ga_q >> 1;
						gb_q <= gb_q >> 1;
						sh_q <= sh_q + 1'b1;
					end else begin
						state_q <= S_G_EUC;
					end
				end
				S_G_EUC: begin
					if (gb_q == '0) begin
						g_q     <= ga_q << sh_q;
						state_q <= gret_q;
					end else begin
						dret_q  <= S_G_STEP;
						state_q <= S_DIV_WAIT;
					end
				end
				S_G_STEP: begin
					ga_q    <= gb_q;
					gb_q    <= div_rsp.rem;
					state_q <= S_G_EUC;
				end
				S_DIV_WAIT: begin
					if (div_rsp.done) state_q <= dret_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign res_num  = res_num_q;
	assign res_den  = res_den_q;
	assign relation = relation_q;
	assign status   = status_q;

endmodule

// ===== rtl/core/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module rau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] res_num,
	input logic [30:0] res_den,
	input logic [1:0]  relation,
	input logic [1:0]  status
);

	// an accepted item either starts work or answers at once
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done) else $error("accepted item lost");

	// results never carry a zero denominator
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res_den != '0) else $error("zero result denominator");

	// error results are the fixed zero fraction with equal relation
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != rau_pkg::ST_OK |->
		res_num == '0 && res_den == 31'd1 && relation == rau_pkg::REL_EQUAL)
		else $error("malformed error result");

	// an ordering outcome comes only from a good compare
	a_cmp_shape: assert property (@(posedge clk) disable iff (!arst_n)
		done && relation != rau_pkg::REL_EQUAL |->
		status == rau_pkg::ST_OK && res_num == '0 && res_den == 31'd1)
		else $error("malformed compare result");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.res_num(res_num), .res_den(res_den), .relation(relation), .status(status)
);
